// ----- rtl/box_blur_3x3_edge_clamped_assert.svh -----
// Assertion macros used by the box blur top level.
`ifndef BOX_BLUR_3X3_EDGE_CLAMPED_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_CLAMPED_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define BB3_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bb3_pkg.sv -----
// Shared constants and types of the 3x3 box blur.
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

   // Default sizing
   localparam int MAX_SIDE_DEF     = 1024;
   localparam int CHANNEL_BITS_DEF = 8;

   // Side register
   localparam int SIDE_BITS  = 11;
   localparam int SIDE_RESET = 512;

   // Channels per pixel (red, green, blue, alpha from the low bits up)
   localparam int NUM_CH = 4;

   // Number of window rows or columns that fall inside the image (1 to 3)
   typedef logic [1:0] span_type;

   typedef struct packed {
      span_type rows;
      span_type cols;
   } span_pair_type;

endpackage

`default_nettype wire

// ----- rtl/bb3_line_store.sv -----
// Two-row line store: one entry per column, registered read with same-edge write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module bb3_line_store #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] line_mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;
   logic [WIDTH-1:0] fwd_data_ff;
   logic             fwd_sel_ff;

   // Memory write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; a write to the same column on the same edge is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff       <= line_mem[rd_addr];
         fwd_sel_ff  <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_sel_ff ? fwd_data_ff : rd_ff;

endmodule

`default_nettype wire

// ----- rtl/bb3_mean.sv -----
// Per-channel window sum divided by the number of pixels inside the image.
`timescale 1ns / 1ps
`default_nettype none

module bb3_mean #(
   parameter int CHANNEL_BITS = 8
) (
   input  wire logic [bb3_pkg::NUM_CH*(CHANNEL_BITS+4)-1:0] sums,
   input  wire bb3_pkg::span_pair_type                      span,
   output logic      [bb3_pkg::NUM_CH*CHANNEL_BITS-1:0]     means
);

   import bb3_pkg::*;

   // Sums of up to nine pixels need four extra bits
   localparam int SUMW = CHANNEL_BITS + 4;
   // Reciprocal scaling: exact truncating quotient for every sum and divisor up to 9
   localparam int SH   = SUMW + 4;
   localparam int MW   = SH + 1;
   localparam int PRW  = SUMW + MW;

   localparam logic [MW-1:0] RECIP_1 = MW'(1 << SH);
   localparam logic [MW-1:0] RECIP_2 = MW'(1 << (SH - 1));
   localparam logic [MW-1:0] RECIP_3 = MW'(((1 << SH) + 2) / 3);
   localparam logic [MW-1:0] RECIP_4 = MW'(1 << (SH - 2));
   localparam logic [MW-1:0] RECIP_6 = MW'(((1 << SH) + 5) / 6);
   localparam logic [MW-1:0] RECIP_9 = MW'(((1 << SH) + 8) / 9);

   logic [3:0]     divisor;
   logic [MW-1:0]  recip;
   logic [PRW-1:0] prod [NUM_CH];

   // Pick the reciprocal of rows * columns
   always_comb begin
      divisor = 4'(span.rows) * 4'(span.cols);
      case (divisor)
         4'd2:    recip = RECIP_2;
         4'd3:    recip = RECIP_3;
         4'd4:    recip = RECIP_4;
         4'd6:    recip = RECIP_6;
         4'd9:    recip = RECIP_9;
         default: recip = RECIP_1;
      endcase
   end

   // One multiplier per channel, quotient taken from the upper product bits
   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         prod[k] = PRW'(sums[k*SUMW +: SUMW]) * PRW'(recip);
         means[k*CHANNEL_BITS +: CHANNEL_BITS] = prod[k][SH +: CHANNEL_BITS];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/box_blur_3x3_edge_clamped.sv -----
// Top level of the streaming 3x3 box blur with clipped borders.
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_3x3_edge_clamped_assert.svh"

// Streaming 3x3 mean filter over a square RGBA image of csr side by side pixels,
// raster order. One request is taken per clock while req_ready is high; a request
// is accepted whenever the input register is free or moves on in the same cycle, so
// a full result register alone does not hold the source back. Each request passes
// an input register (line-store read) and a window/sum register, then a reciprocal
// multiply into the result register, whose valid flag drives rsp_valid. The line store
// is one MAX_SIDE-entry memory holding the two rows above, read and written once per
// request; it needs no clearing pass. The result for pixel k leaves with request
// k+side+1; after side*side pixels the source sends side+1 flush requests (position
// decides, req_drain is informational). Writing the side register restarts the frame
// position; write it only while idle.
module box_blur_3x3_edge_clamped #(
   parameter int MAX_SIDE     = bb3_pkg::MAX_SIDE_DEF,
   parameter int CHANNEL_BITS = bb3_pkg::CHANNEL_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [CHANNEL_BITS-1:0]       req_red_in,
   input  wire logic [CHANNEL_BITS-1:0]       req_green_in,
   input  wire logic [CHANNEL_BITS-1:0]       req_blue_in,
   input  wire logic [CHANNEL_BITS-1:0]       req_alpha_in,
   input  wire logic                          req_drain,
   // Response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [CHANNEL_BITS-1:0]       rsp_red_out,
   output logic      [CHANNEL_BITS-1:0]       rsp_green_out,
   output logic      [CHANNEL_BITS-1:0]       rsp_blue_out,
   output logic      [CHANNEL_BITS-1:0]       rsp_alpha_out,
   output logic                               rsp_frame_end,
   // Side register
   input  wire logic                          csr_write,
   input  wire logic [bb3_pkg::SIDE_BITS-1:0] csr_wdata
);

   import bb3_pkg::*;

   localparam int AW   = $clog2(MAX_SIDE);
   localparam int RW   = $clog2(MAX_SIDE + 2);
   localparam int XW   = (SIDE_BITS > RW) ? SIDE_BITS : RW;
   localparam int PW   = NUM_CH * CHANNEL_BITS;
   localparam int SUMW = CHANNEL_BITS + 4;
   localparam logic [RW-1:0] SIDE_AT_RESET =
      (SIDE_RESET > MAX_SIDE) ? RW'(MAX_SIDE) : RW'(SIDE_RESET);

   // Side register and frame position
   logic [XW-1:0] csr_x;
   logic [RW-1:0] side_in, side_ff;
   logic [RW-1:0] row_in, row_ff;
   logic [AW-1:0] col_in, col_ff;
   logic [RW-1:0] col_x, side_p1, side_m1;

   // Request decode
   logic          accept;
   logic          is_pix, is_tail, is_mid, is_last;
   logic [2:0]    rows_in, cols_in;
   logic [PW-1:0] pix_in;

   // Input register stage
   logic          s1_valid_ff, s1_fire;
   logic [PW-1:0] s1_pix_ff;
   logic [AW-1:0] s1_col_ff;
   logic          s1_tail_ff, s1_emit_ff, s1_last_ff;
   logic [2:0]    s1_rows_ff, s1_cols_ff;
   logic [2*PW-1:0] line_rd;

   // Window, indexed [row top..bottom][column oldest..newest]
   logic [PW-1:0] win_ff  [3][3];
   logic [PW-1:0] win_nx  [3][3];
   logic [PW-1:0] win_sel [3][3];
   logic [NUM_CH*SUMW-1:0] sum_in;
   span_pair_type          span_in;

   // Sum stage
   logic                   s2_valid_ff, s2_fire, s2_free;
   logic [NUM_CH*SUMW-1:0] s2_sum_ff;
   span_pair_type          s2_span_ff;
   logic                   s2_last_ff;
   logic [PW-1:0]          mean_w;

   // Result register
   logic          rsp_valid_ff, out_free;
   logic [PW-1:0] rsp_pix_ff;
   logic          rsp_last_ff;

   // Handshake chain
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_fire   = s2_valid_ff && out_free;
   assign s2_free   = !s2_valid_ff || s2_fire;
   assign s1_fire   = s1_valid_ff && (!s1_emit_ff || s2_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign accept    = req_valid && req_ready;

   // Clamp the written side to 1..MAX_SIDE
   always_comb begin
      csr_x = XW'(csr_wdata);
      if (csr_x == '0) begin
         side_in = RW'(1);
      end else if (csr_x > XW'(MAX_SIDE)) begin
         side_in = RW'(MAX_SIDE);
      end else begin
         side_in = RW'(csr_x);
      end
   end

   // Position decode and next position
   always_comb begin
      col_x   = RW'(col_ff);
      side_p1 = side_ff + RW'(1);
      side_m1 = side_ff - RW'(1);
      is_pix  = row_ff < side_ff;
      is_last = row_ff == side_p1;
      is_tail = (col_ff == '0) && (row_ff >= RW'(2));
      is_mid  = (col_ff != '0) && (row_ff >= RW'(1)) && (row_ff <= side_ff);
      pix_in  = is_pix ? {req_alpha_in, req_blue_in, req_green_in, req_red_in} : '0;

      // Clipping masks: tail finishes the last column of the row two above;
      // its oldest window column lies two columns left of the center
      if (is_tail) begin
         cols_in = {1'b1, side_ff >= RW'(2), 1'b0};
         rows_in = {row_ff <= side_ff, 1'b1, row_ff >= RW'(3)};
      end else begin
         cols_in = {1'b1, 1'b1, col_x >= RW'(2)};
         rows_in = {row_ff < side_ff, 1'b1, row_ff >= RW'(2)};
      end

      if (is_last) begin
         row_in = '0;
         col_in = '0;
      end else if (col_x == side_m1) begin
         row_in = row_ff + RW'(1);
         col_in = '0;
      end else begin
         row_in = row_ff;
         col_in = AW'(col_x + RW'(1));
      end
   end

   // Side register and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_AT_RESET;
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (csr_write) begin
         side_ff <= side_in;
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (accept) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= pix_in;
         s1_col_ff  <= col_ff;
         s1_tail_ff <= is_tail;
         s1_emit_ff <= is_tail || is_mid;
         s1_last_ff <= is_last;
         s1_rows_ff <= rows_in;
         s1_cols_ff <= cols_in;
      end
   end

   // Rows above: upper half older row, lower half newer row
   bb3_line_store #(
      .DEPTH (MAX_SIDE),
      .WIDTH (2 * PW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data ({line_rd[PW-1:0], s1_pix_ff}),
      .rd_data (line_rd)
   );

   // Window shift; tail results use the window before the shift
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_nx[i][0] = win_ff[i][1];
         win_nx[i][1] = win_ff[i][2];
      end
      win_nx[0][2] = line_rd[2*PW-1:PW];
      win_nx[1][2] = line_rd[PW-1:0];
      win_nx[2][2] = s1_pix_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            win_sel[i][j] = s1_tail_ff ? win_ff[i][j] : win_nx[i][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         win_ff <= win_nx;
      end
   end

   // Masked window sums and pixel counts
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < NUM_CH; k++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               if (s1_rows_ff[i] && s1_cols_ff[j]) begin
                  sum_in[k*SUMW +: SUMW] = sum_in[k*SUMW +: SUMW]
                     + SUMW'(win_sel[i][j][k*CHANNEL_BITS +: CHANNEL_BITS]);
               end
            end
         end
      end
      span_in.rows = 2'(s1_rows_ff[0]) + 2'(s1_rows_ff[1]) + 2'(s1_rows_ff[2]);
      span_in.cols = 2'(s1_cols_ff[0]) + 2'(s1_cols_ff[1]) + 2'(s1_cols_ff[2]);
   end

   // Sum register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_fire && s1_emit_ff) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_fire) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_emit_ff) begin
         s2_sum_ff  <= sum_in;
         s2_span_ff <= span_in;
         s2_last_ff <= s1_last_ff;
      end
   end

   bb3_mean #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_mean (
      .sums  (s2_sum_ff),
      .span  (s2_span_ff),
      .means (mean_w)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         rsp_pix_ff  <= mean_w;
         rsp_last_ff <= s2_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_pix_ff[0*CHANNEL_BITS +: CHANNEL_BITS];
   assign rsp_green_out = rsp_pix_ff[1*CHANNEL_BITS +: CHANNEL_BITS];
   assign rsp_blue_out  = rsp_pix_ff[2*CHANNEL_BITS +: CHANNEL_BITS];
   assign rsp_alpha_out = rsp_pix_ff[3*CHANNEL_BITS +: CHANNEL_BITS];
   assign rsp_frame_end = rsp_last_ff;

   // req_drain carries no control: the frame position alone marks flush requests.

   // Checks
   `BB3_ASSERT_ALWAYS(a_col_in_range, RW'(col_ff) < side_ff, "column counter beyond image side")
   `BB3_ASSERT_ALWAYS(a_row_in_range,
      (row_ff < side_p1) || ((row_ff == side_p1) && (col_ff == '0)),
      "row counter beyond flush position")
   `BB3_ASSERT_NEXT(a_rearm, accept && is_last && !csr_write,
      (row_ff == '0) && (col_ff == '0), "position not rearmed after last flush request")
   `BB3_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !s1_fire, s1_valid_ff,
      "input register lost a stalled request")
   `BB3_ASSERT_NEXT(a_s2_hold, s2_valid_ff && !s2_fire, s2_valid_ff,
      "sum register lost a stalled result")

endmodule

`default_nettype wire
